// ===== hw/rtl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg: shared types and constants for the line draw setup block
// Operation codes, direction flags, the result word layout and queue depth.
// ----------------------------------------------------------------------------
package lds_pkg;

   // Input operation codes, carried on req_tuser.
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // Depth of the queue between the classifier and the setup engine.
   localparam int QUEUE_DEPTH = 2;

   // Width of the packed result word on rsp_tdata.
   localparam int RSP_DATA_W = 80;

   typedef logic        [11:0] coord_out_type;
   typedef logic signed [13:0] err_type;
   typedef logic        [12:0] axial_type;
   typedef logic signed [12:0] diag_type;

   // Direction and major-axis flags of one line.
   typedef struct packed {
      logic step_x_up;
      logic step_y_up;
      logic y_is_major;
   } dir_type;

   // Result word, first member in the highest bits.
   typedef struct packed {
      logic          zero_pad;
      logic          y_is_major;
      logic          step_y_up;
      logic          step_x_up;
      coord_out_type major_length;
      diag_type      diagonal_step;
      axial_type     axial_step;
      err_type       error_start;
      coord_out_type start_y;
      coord_out_type start_x;
   } rsp_type;

endpackage

// ===== hw/rtl/lds_front.sv =====
// ----------------------------------------------------------------------------
// lds_front: request classifier and pen register
// Moves update the pen; draws are reduced to start point, major and minor
// lengths and direction flags and pushed into the queue.
// ----------------------------------------------------------------------------
module lds_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*COORD_BITS-1:0]   req_tdata,   // point_x, point_y
   input  logic                      req_tuser,   // operation
   output logic                      push_valid,
   input  logic                      push_ready,
   output logic [4*COORD_BITS+2:0]   push_data
);

   logic [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic [COORD_BITS-1:0] point_x, point_y;
   logic [COORD_BITS-1:0] adx, ady, major, minor;
   lds_pkg::dir_type      dir;
   logic                  accept;

   assign point_x = req_tdata[COORD_BITS-1:0];
   assign point_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   // Both differences are formed at once and the non-negative one is kept.
   assign dir.step_x_up  = point_x >= pen_x_ff;
   assign dir.step_y_up  = point_y >= pen_y_ff;
   assign adx = dir.step_x_up ? point_x - pen_x_ff : pen_x_ff - point_x;
   assign ady = dir.step_y_up ? point_y - pen_y_ff : pen_y_ff - point_y;
   assign dir.y_is_major = ady >= adx;
   assign major = dir.y_is_major ? ady : adx;
   assign minor = dir.y_is_major ? adx : ady;

   // A draw to the pen position itself has no length and is dropped here.
   assign push_valid = accept && (req_tuser == lds_pkg::OP_DRAW) && (major != '0);
   assign push_data  = {dir, minor, major, pen_y_ff, pen_x_ff};

   always_comb begin
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      if (accept && (req_tuser == lds_pkg::OP_MOVE)) begin
         pen_x_in = point_x;
         pen_y_in = point_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

endmodule

// ===== hw/rtl/lds_queue.sv =====
// ----------------------------------------------------------------------------
// lds_queue: short first-in first-out queue
// Decouples the classifier from the setup engine.
// ----------------------------------------------------------------------------
module lds_queue #(
   parameter int WIDTH = 51
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = lds_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/lds_back.sv =====
// ----------------------------------------------------------------------------
// lds_back: Bresenham setup engine
// Forms the three error terms, scales them when they exceed the limit with a
// shared serial divider, applies the start error fix and holds the result.
// ----------------------------------------------------------------------------
module lds_back #(
   parameter int COORD_BITS  = 12,
   parameter int ERROR_LIMIT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  logic [4*COORD_BITS+2:0]         pop_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lds_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int C       = COORD_BITS;
   localparam int TW      = C + 1;
   localparam int Q       = $clog2(ERROR_LIMIT + 1);
   localparam int DIV_MAX = (2 * ((1 << C) - 1) + ERROR_LIMIT - 1) / ERROR_LIMIT;
   localparam int D       = (DIV_MAX > 1) ? $clog2(DIV_MAX + 1) : 1;
   localparam int LW      = (TW > D + Q) ? TW : D + Q;
   localparam int CW      = (TW > Q + 1) ? TW : Q + 1;
   localparam int CNT_W   = $clog2(Q);
   localparam int TERMS   = 3;

   localparam logic [CW-1:0] LIMIT_C = CW'(ERROR_LIMIT);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TERMS = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_DIVT  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [C-1:0]       start_x_ff, start_x_in;
   logic [C-1:0]       start_y_ff, start_y_in;
   logic [C-1:0]       major_ff, major_in;
   logic [C-1:0]       minor_ff, minor_in;
   lds_pkg::dir_type   dir_ff, dir_in;
   logic [TW-1:0]      m_ff [TERMS];
   logic [TW-1:0]      m_in [TERMS];
   logic               sign_e_ff, sign_e_in;
   logic [TW-1:0]      big_ff, big_in;
   logic [D-1:0]       div_ff, div_in;
   logic [LW-1:0]      lrem_ff [TERMS];
   logic [LW-1:0]      lrem_in [TERMS];
   logic [LW-1:0]      ddiv_ff, ddiv_in;
   logic [Q-1:0]       q_ff [TERMS];
   logic [Q-1:0]       q_in [TERMS];
   lds_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0]      two_minor, major_ext, m0_calc, m2_calc, big_calc;
   logic               ge, need_scale;
   logic [D-1:0]       div_calc;
   logic [TERMS-1:0]   lbit;
   logic signed [Q+1:0] e_mag, e_val, d_val;

   assign two_minor = {minor_ff, 1'b0};
   assign major_ext = {1'b0, major_ff};
   assign ge        = two_minor >= major_ext;
   assign m0_calc   = ge ? two_minor - major_ext : major_ext - two_minor;
   assign m2_calc   = {major_ff - minor_ff, 1'b0};
   // The start error never exceeds the larger of the two steps, whose
   // magnitudes sum to twice the major length.
   assign big_calc  = ge ? two_minor : m2_calc;

   assign need_scale = CW'(big_ff) > LIMIT_C;

   // Divisor ceil(largest / limit): the largest term is compared with each
   // multiple of the limit below its highest possible value.
   always_comb begin
      div_calc = D'(1);
      for (int k = 1; k < DIV_MAX; k++) begin
         if (big_ff > TW'(k * ERROR_LIMIT)) begin
            div_calc = D'(k + 1);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < TERMS; k++) begin
         lbit[k] = lrem_ff[k] >= ddiv_ff;
      end
   end

   assign e_mag = $signed({2'b00, q_ff[0]});
   assign e_val = (sign_e_ff ? -e_mag : e_mag)
                - $signed({{(Q + 1){1'b0}}, dir_ff.step_x_up});
   assign d_val = -$signed({2'b00, q_ff[2]});

   assign pop_ready  = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      dir_in       = dir_ff;
      m_in         = m_ff;
      sign_e_in    = sign_e_ff;
      big_in       = big_ff;
      div_in       = div_ff;
      lrem_in      = lrem_ff;
      ddiv_in      = ddiv_ff;
      q_in         = q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               start_x_in = pop_data[C-1:0];
               start_y_in = pop_data[2*C-1:C];
               major_in   = pop_data[3*C-1:2*C];
               minor_in   = pop_data[4*C-1:3*C];
               dir_in     = lds_pkg::dir_type'(pop_data[4*C+2:4*C]);
               state_in   = ST_TERMS;
            end
         end
         ST_TERMS: begin
            m_in[0]   = m0_calc;
            m_in[1]   = two_minor;
            m_in[2]   = m2_calc;
            sign_e_in = !ge;
            big_in    = big_calc;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (need_scale) begin
               div_in = div_calc;
               for (int k = 0; k < TERMS; k++) begin
                  lrem_in[k] = LW'(m_ff[k]);
                  q_in[k]    = '0;
               end
               ddiv_in  = LW'(div_calc) << (Q - 1);
               cnt_in   = CNT_W'(Q - 1);
               state_in = ST_DIVT;
            end else begin
               for (int k = 0; k < TERMS; k++) begin
                  q_in[k] = Q'(m_ff[k]);
               end
               state_in = ST_EMIT;
            end
         end
         ST_DIVT: begin
            // Three quotients share the divisor; each is below 2**Q.
            for (int k = 0; k < TERMS; k++) begin
               if (lbit[k]) begin
                  lrem_in[k] = lrem_ff[k] - ddiv_ff;
               end
               q_in[k] = Q'({q_ff[k], lbit[k]});
            end
            ddiv_in = ddiv_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.zero_pad      = 1'b0;
               rsp_in.y_is_major    = dir_ff.y_is_major;
               rsp_in.step_y_up     = dir_ff.step_y_up;
               rsp_in.step_x_up     = dir_ff.step_x_up;
               rsp_in.major_length  = lds_pkg::coord_out_type'(major_ff);
               rsp_in.diagonal_step = lds_pkg::diag_type'(d_val);
               rsp_in.axial_step    = lds_pkg::axial_type'(q_ff[1]);
               rsp_in.error_start   = lds_pkg::err_type'(e_val);
               rsp_in.start_y       = lds_pkg::coord_out_type'(start_y_ff);
               rsp_in.start_x       = lds_pkg::coord_out_type'(start_x_ff);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      major_ff   <= major_in;
      minor_ff   <= minor_in;
      dir_ff     <= dir_in;
      m_ff       <= m_in;
      sign_e_ff  <= sign_e_in;
      big_ff     <= big_in;
      div_ff     <= div_in;
      lrem_ff    <= lrem_in;
      ddiv_ff    <= ddiv_in;
      q_ff       <= q_in;
      rsp_ff     <= rsp_in;
   end

   // A result leaving the engine must land in the output register.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("emitted result not held in output register");

   // The scaling divisor, at least two whenever the terms are divided, is checked to be nonzero.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVT) |-> (div_ff != '0))
      else $error("scaling with a zero divisor");

   // Scaled or not, the axial step never exceeds the error limit.
   a_axial_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_ff.axial_step) <= ERROR_LIMIT))
      else $error("axial step above error limit");

endmodule

// ===== hw/rtl/line_draw_setup.sv =====
// ----------------------------------------------------------------------------
// line_draw_setup: Bresenham line setup for a line accelerator
// A move transfer stores the pen position; a draw transfer produces the
// direction flags, major length and the three error terms for one line.
// A move is handled in the front end alone and produces nothing. A draw
// passes through a two-entry queue into the setup engine, which takes it
// in idle, steps through the terms, check and emit states and takes the
// next draw only back in idle. When an error term exceeds ERROR_LIMIT, the
// scaling divisor is found in the check state by comparing the largest
// term with multiples of ERROR_LIMIT, and a serial divider then divides
// all three terms in parallel, one quotient bit per cycle, into Q-bit
// quotients, where Q = clog2(ERROR_LIMIT + 1). A draw whose endpoint
// equals the pen produces no result, and a draw leaves the pen
// where it was.
// ----------------------------------------------------------------------------
module line_draw_setup #(
   parameter int COORD_BITS  = 12,
   parameter int ERROR_LIMIT = 4096
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // point_x, point_y, zero fill to whole bytes
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   // operation
   input  logic                                      req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // start_x, start_y, error_start, axial_step, diagonal_step,
   // major_length, step_x_up, step_y_up, y_is_major, zero fill
   output logic [lds_pkg::RSP_DATA_W-1:0]            rsp_tdata
);

   localparam int ITEM_W = 4 * COORD_BITS + 3;

   logic              push_valid, push_ready;
   logic [ITEM_W-1:0] push_data;
   logic              pop_valid, pop_ready;
   logic [ITEM_W-1:0] pop_data;

   lds_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata[2*COORD_BITS-1:0]),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   lds_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lds_back #(
      .COORD_BITS  (COORD_BITS),
      .ERROR_LIMIT (ERROR_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== bench/tb_line_draw_setup.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_draw_setup: self-checking bench for the line draw setup block
// Move and draw transfers go in on the request stream. A line setup predictor
// with its own pen position computes each expected result. A checker compares
// every result transfer field by field with the oldest expected setup.
// Both stream sides idle at random, and the response side holds off once for
// a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_line_draw_setup;

   localparam int COORD_BITS  = 12;
   localparam int ERROR_LIMIT = 4096;
   localparam int COORD_MAX   = 4095;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [lds_pkg::RSP_DATA_W-1:0] rsp_tdata;

   line_draw_setup #(
      .COORD_BITS  (COORD_BITS),
      .ERROR_LIMIT (ERROR_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predictor state and the setups still awaited on the response stream.
   logic [11:0]      pen_x_model;
   logic [11:0]      pen_y_model;
   lds_pkg::rsp_type pending_setups[$];

   int  mismatches;
   int  cycle_count;
   int  rsp_hold_cycles;
   int  rsp_stall_left;
   bit  req_idle_on;
   bit  rsp_stall_on;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Bresenham setup for one accepted transfer. A move only updates the pen.
   function automatic void predict_line_setup(input logic op, input logic [11:0] x,
                                              input logic [11:0] y);
      int               dx, dy, adx, ady, e, e1, e2, len, big, div, fix, err;
      lds_pkg::rsp_type exp;
      if (op == lds_pkg::OP_MOVE) begin
         pen_x_model = x;
         pen_y_model = y;
         return;
      end
      dx  = int'(x) - int'(pen_x_model);
      dy  = int'(y) - int'(pen_y_model);
      adx = abs_int(dx);
      ady = abs_int(dy);
      fix = (dx >= 0) ? -1 : 0;
      exp = '0;
      exp.step_x_up = (dx >= 0);
      exp.step_y_up = (dy >= 0);
      if (adx > ady) begin
         exp.y_is_major = 1'b0;
         e1  = 2 * ady;
         e2  = e1 - 2 * adx;
         e   = e1 - adx;
         len = adx;
      end else begin
         exp.y_is_major = 1'b1;
         e1  = 2 * adx;
         e2  = e1 - 2 * ady;
         e   = e1 - ady;
         len = ady;
      end
      if (len == 0) begin
         return;
      end
      big = abs_int(e);
      if (abs_int(e1) > big) big = abs_int(e1);
      if (abs_int(e2) > big) big = abs_int(e2);
      if (big > ERROR_LIMIT) begin
         // Integer division on int truncates toward zero.
         div = (big + ERROR_LIMIT - 1) / ERROR_LIMIT;
         e  = e / div;
         e1 = e1 / div;
         e2 = e2 / div;
      end
      err = e + fix;
      exp.start_x       = pen_x_model;
      exp.start_y       = pen_y_model;
      exp.error_start   = err[13:0];
      exp.axial_step    = e1[12:0];
      exp.diagonal_step = e2[12:0];
      exp.major_length  = len[11:0];
      pending_setups.push_back(exp);
   endfunction

   // Offer one transfer at the falling edge, hold it until accepted, then
   // optionally leave the request side idle for a while.
   task automatic send_item(input logic op, input logic [11:0] x, input logic [11:0] y);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {y, x};
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_line_setup(op, x, y);
      gap = 0;
      if (req_idle_on && $urandom_range(0, 2) != 0) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tuser  <= 1'($urandom_range(0, 1));
         req_tdata  <= 24'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Response side: a long hold-off when asked, otherwise random stalls.
   always begin
      @(negedge clock);
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         if (rsp_stall_on && rsp_stall_left == 0 && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = pick_gap();
         end
         if (rsp_stall_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall_left = rsp_stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checker: each result transfer against the oldest expected setup.
   always @(posedge clock) begin
      lds_pkg::rsp_type got;
      lds_pkg::rsp_type exp;
      got = lds_pkg::rsp_type'(rsp_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_setups.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result with no pending setup, start (%0d,%0d) len %0d",
                        got.start_x, got.start_y, got.major_length);
            end
         end else begin
            exp = pending_setups.pop_front();
            if (got.start_x !== exp.start_x || got.start_y !== exp.start_y ||
                got.error_start !== exp.error_start ||
                got.axial_step !== exp.axial_step ||
                got.diagonal_step !== exp.diagonal_step ||
                got.major_length !== exp.major_length ||
                got.step_x_up !== exp.step_x_up || got.step_y_up !== exp.step_y_up ||
                got.y_is_major !== exp.y_is_major || got.zero_pad !== 1'b0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: setup mismatch");
                  $display("  expected start (%0d,%0d) err %0d axial %0d diag %0d len %0d",
                           exp.start_x, exp.start_y, exp.error_start, exp.axial_step,
                           exp.diagonal_step, exp.major_length);
                  $display("           xup %b yup %b ymaj %b",
                           exp.step_x_up, exp.step_y_up, exp.y_is_major);
                  $display("  actual   start (%0d,%0d) err %0d axial %0d diag %0d len %0d",
                           got.start_x, got.start_y, got.error_start, got.axial_step,
                           got.diagonal_step, got.major_length);
                  $display("           xup %b yup %b ymaj %b pad %b",
                           got.step_x_up, got.step_y_up, got.y_is_major, got.zero_pad);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Extremes, both directions on each axis, axis ties, the scaling boundary
   // and zero-length draws, including one against the reset pen.
   task automatic test_directed();
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      send_item(lds_pkg::OP_DRAW, 12'd0, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd4095, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd0, 12'd4095);
      send_item(lds_pkg::OP_DRAW, 12'd4095, 12'd4095);
      send_item(lds_pkg::OP_DRAW, 12'd2048, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd2049, 12'd0);
      send_item(lds_pkg::OP_MOVE, 12'd4095, 12'd4095);
      send_item(lds_pkg::OP_DRAW, 12'd0, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd0, 12'd4095);
      send_item(lds_pkg::OP_DRAW, 12'd4095, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd4095, 12'd4095);
      send_item(lds_pkg::OP_MOVE, 12'd2048, 12'd2048);
      send_item(lds_pkg::OP_DRAW, 12'd2049, 12'd2048);
      send_item(lds_pkg::OP_DRAW, 12'd2048, 12'd2047);
      send_item(lds_pkg::OP_DRAW, 12'd2047, 12'd2049);
      send_item(lds_pkg::OP_DRAW, 12'd2047, 12'd2047);
      send_item(lds_pkg::OP_DRAW, 12'd2048, 12'd2048);
      send_item(lds_pkg::OP_MOVE, 12'hAAA, 12'h555);
      send_item(lds_pkg::OP_DRAW, 12'h555, 12'hAAA);
      send_item(lds_pkg::OP_DRAW, 12'hFFF, 12'h554);
      send_item(lds_pkg::OP_MOVE, 12'd0, 12'd0);
      send_item(lds_pkg::OP_DRAW, 12'd4095, 12'd1);
   endtask

   // The response side holds off for a long stretch while draws keep coming,
   // so the queue fills and the request side must stall.
   task automatic test_rsp_hold();
      int i;
      req_idle_on     = 1'b0;
      rsp_stall_on    = 1'b0;
      rsp_hold_cycles = 300;
      for (i = 0; i < 20; i++) begin
         send_item(lds_pkg::OP_DRAW, 12'($urandom_range(0, COORD_MAX)),
                   12'($urandom_range(0, COORD_MAX)));
      end
   endtask

   // Random moves and draws in phases with and without idling on each side.
   task automatic test_random(input int count);
      int          i, kind, tx, ty;
      logic        op;
      logic [11:0] x, y;
      for (i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            req_idle_on  = (i / 50) % 4 != 1;
            rsp_stall_on = (i / 50) % 4 != 2;
         end
         op   = ($urandom_range(0, 9) < 7) ? lds_pkg::OP_DRAW : lds_pkg::OP_MOVE;
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            tx = $urandom_range(0, COORD_MAX);
            ty = $urandom_range(0, COORD_MAX);
         end else if (kind < 7) begin
            // Short lines stay below the scaling limit.
            tx = int'(pen_x_model) + $urandom_range(0, 1200) - 600;
            ty = int'(pen_y_model) + $urandom_range(0, 1200) - 600;
         end else if (kind == 7) begin
            tx = $urandom_range(0, 1) ? COORD_MAX : 0;
            ty = $urandom_range(0, 1) ? COORD_MAX : 0;
         end else if (kind == 8) begin
            tx = int'(pen_x_model);
            ty = int'(pen_y_model);
         end else begin
            // Equal axes or one axis unchanged.
            tx = $urandom_range(0, 2000) - 1000;
            ty = $urandom_range(0, 1) ? tx : 0;
            if ($urandom_range(0, 1)) ty = -ty;
            if ($urandom_range(0, 1)) begin
               tx = 0;
               ty = $urandom_range(1, 1500);
            end
            tx = int'(pen_x_model) + tx;
            ty = int'(pen_y_model) + ty;
         end
         if (tx < 0) tx = 0;
         if (tx > COORD_MAX) tx = COORD_MAX;
         if (ty < 0) ty = 0;
         if (ty > COORD_MAX) ty = COORD_MAX;
         x = tx[11:0];
         y = ty[11:0];
         send_item(op, x, y);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      rsp_tready      = 1'b0;
      pen_x_model     = '0;
      pen_y_model     = '0;
      mismatches      = 0;
      cycle_count     = 0;
      rsp_hold_cycles = 0;
      rsp_stall_left  = 0;
      req_idle_on     = 1'b0;
      rsp_stall_on    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_rsp_hold();
      test_random(420);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_setups.size() != 0) begin
         @(posedge clock);
      end
      // Keep the checker running so that a stray extra result is still caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_setups.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== line_draw_setup.f =====
hw/rtl/lds_pkg.sv
hw/rtl/lds_front.sv
hw/rtl/lds_queue.sv
hw/rtl/lds_back.sv
hw/rtl/line_draw_setup.sv
bench/tb_line_draw_setup.sv
